// ----- src/pvkf_pkg.sv -----
// Package: shared types, constants and saturation helper for the position/velocity filter.
`timescale 1ns / 1ps
`default_nettype none
package pvkf_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int MERR_W = 31;
	localparam int DT_W = 20;
	localparam int GAIN_W = FRAC_W + 1;
	localparam int MA_W = 36;
	localparam int MB_W = 21;
	localparam int PROD_W = MA_W + MB_W;
	localparam int SH16_W = PROD_W - FRAC_W;
	localparam int SH17_W = PROD_W - FRAC_W - 1;
	localparam int SAT_W = 42;
	localparam int DIVR_W = 34;
	localparam int DIVS_W = 33;
	localparam int DIVC_W = 5;

	localparam logic signed [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] FX_UNSET = -(DATA_W'(1) <<< FRAC_W);
	localparam logic signed [DATA_W-1:0] FX_TEN = DATA_W'(10) <<< FRAC_W;
	localparam logic [GAIN_W:0] FX_ONE_G = (GAIN_W + 1)'(1) << FRAC_W;
	localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(GAIN_W - 1);
	localparam logic signed [MB_W-1:0] RESET_SCALE = MB_W'(1000);

	typedef enum logic [2:0] {
		CMD_LOAD     = 3'd0,
		CMD_UPD_BOTH = 3'd1,
		CMD_UPD_POS  = 3'd2,
		CMD_UPD_VEL  = 3'd3,
		CMD_PREDICT  = 3'd4,
		CMD_RESET    = 3'd5,
		CMD_CLEAR    = 3'd6,
		CMD_NOP      = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [2:0]               command;
		logic signed [DATA_W-1:0] position;
		logic signed [DATA_W-1:0] velocity;
		logic [MERR_W-1:0]        pos_meas_err;
		logic [MERR_W-1:0]        vel_meas_err;
		logic signed [DATA_W-1:0] accel;
		logic [MERR_W-1:0]        accel_err;
		logic [DT_W-1:0]          time_step;
	} meas_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] pos_estimate;
		logic signed [DATA_W-1:0] vel_estimate;
		logic signed [DATA_W-1:0] pos_error;
		logic signed [DATA_W-1:0] vel_error;
		logic                     saturated;
	} est_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LATCH, OP_LOAD, OP_CLEAR, OP_ADOPT, OP_DIV_INIT, OP_DIV_STEP,
		OP_BMUL1, OP_BMUL2, OP_BWR, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5,
		OP_R1, OP_R2, OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_BCHK, ST_BDIV, ST_BM1, ST_BM2, ST_BWR,
		ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_R1, ST_R2, ST_DONE
	} state_t;

	typedef struct packed {
		op_t  op;
		logic ch;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t command;
		logic err_unset;
		logic div_last;
		logic out_busy;
	} dp_stat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     clip;
	} sat_res_t;

	function automatic sat_res_t sat_fx(input logic signed [SAT_W-1:0] x);
		sat_res_t r;
		if (x > SAT_W'(FX_MAX)) begin
			r.val = FX_MAX;
			r.clip = 1'b1;
		end else if (x < SAT_W'(FX_MIN)) begin
			r.val = FX_MIN;
			r.clip = 1'b1;
		end else begin
			r.val = DATA_W'(x);
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/pvkf_ctrl.sv -----
// Controller: sequences the datapath through each command.
`timescale 1ns / 1ps
`default_nettype none
module pvkf_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 meas_valid,
	output logic                meas_stall,
	input  pvkf_pkg::dp_stat_t  stat,
	output pvkf_pkg::dp_cmd_t   cmd
);
	import pvkf_pkg::*;

	state_t state_q, state_d;
	logic   ch_q, ch_d, both_q, both_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q <= 1'b0;
			both_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ch_q <= ch_d;
			both_q <= both_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ch_d = ch_q;
		both_d = both_q;
		cmd.op = OP_NONE;
		cmd.ch = ch_q;
		meas_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				meas_stall = 1'b0;
				if (meas_valid) begin
					cmd.op = OP_LATCH;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.command)
					CMD_LOAD: begin
						cmd.op = OP_LOAD;
						state_d = ST_DONE;
					end
					CMD_UPD_BOTH: begin
						ch_d = 1'b0;
						both_d = 1'b1;
						state_d = ST_BCHK;
					end
					CMD_UPD_POS: begin
						ch_d = 1'b0;
						both_d = 1'b0;
						state_d = ST_BCHK;
					end
					CMD_UPD_VEL: begin
						ch_d = 1'b1;
						both_d = 1'b0;
						state_d = ST_BCHK;
					end
					CMD_PREDICT: state_d = ST_P1;
					CMD_RESET: state_d = ST_R1;
					CMD_CLEAR: begin
						cmd.op = OP_CLEAR;
						state_d = ST_DONE;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_BCHK: begin
				if (stat.err_unset) begin
					cmd.op = OP_ADOPT;
					if (both_q && !ch_q) begin
						ch_d = 1'b1;
						state_d = ST_BCHK;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					cmd.op = OP_DIV_INIT;
					state_d = ST_BDIV;
				end
			end
			ST_BDIV: begin
				cmd.op = OP_DIV_STEP;
				if (stat.div_last) state_d = ST_BM1;
			end
			ST_BM1: begin
				cmd.op = OP_BMUL1;
				state_d = ST_BM2;
			end
			ST_BM2: begin
				cmd.op = OP_BMUL2;
				state_d = ST_BWR;
			end
			ST_BWR: begin
				cmd.op = OP_BWR;
				if (both_q && !ch_q) begin
					ch_d = 1'b1;
					state_d = ST_BCHK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_P1: begin
				cmd.op = OP_P1;
				state_d = ST_P2;
			end
			ST_P2: begin
				cmd.op = OP_P2;
				state_d = ST_P3;
			end
			ST_P3: begin
				cmd.op = OP_P3;
				state_d = ST_P4;
			end
			ST_P4: begin
				cmd.op = OP_P4;
				state_d = ST_P5;
			end
			ST_P5: begin
				cmd.op = OP_P5;
				state_d = ST_DONE;
			end
			ST_R1: begin
				cmd.op = OP_R1;
				state_d = ST_R2;
			end
			ST_R2: begin
				cmd.op = OP_R2;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.op = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- src/pvkf_dp.sv -----
// Datapath: filter state, shared multiplier, gain divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module pvkf_dp (
	input  wire                clk,
	input  wire                arst_n,
	input  pvkf_pkg::meas_t    meas,
	input  pvkf_pkg::dp_cmd_t  cmd,
	output pvkf_pkg::dp_stat_t stat,
	output logic               est_valid,
	input  wire                est_stall,
	output pvkf_pkg::est_t     est
);
	import pvkf_pkg::*;

	logic signed [DATA_W-1:0] pos_q, vel_q, perr_q, verr_q;
	logic signed [DATA_W-1:0] nv_q, nve_q, np_q;
	logic signed [SH17_W-1:0] h_q, hv_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     sat_q;
	meas_t                    in_q;
	logic [DIVR_W-1:0]        r_q;
	logic [DIVS_W-1:0]        sum_q;
	logic [GAIN_W-1:0]        g_q;
	logic [DIVC_W-1:0]        cnt_q;
	logic                     lsb_q;
	logic                     est_valid_q;
	est_t                     est_q;

	logic signed [DATA_W-1:0] est_sel, err_sel, meas_p, meas_v, meas_sel;
	logic [MERR_W-1:0]        merr_sel;
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [SH16_W-1:0] sh16;
	logic signed [SH17_W-1:0] sh17;
	logic [GAIN_W:0]          one_minus_g;
	logic [DIVR_W-1:0]        rs;
	sat_res_t                 s_est, s_err, s_nv, s_nve, s_np, s_npe, s_rst;

	assign meas_p = in_q.position;
	assign meas_v = in_q.velocity;
	assign est_sel = cmd.ch ? vel_q : pos_q;
	assign err_sel = cmd.ch ? verr_q : perr_q;
	assign meas_sel = cmd.ch ? meas_v : meas_p;
	assign merr_sel = cmd.ch ? in_q.vel_meas_err : in_q.pos_meas_err;
	assign sh16 = $signed(prod_q[PROD_W-1:FRAC_W]);
	assign sh17 = $signed(prod_q[PROD_W-1:FRAC_W+1]);
	assign one_minus_g = FX_ONE_G - {1'b0, g_q};
	assign rs = {r_q[DIVR_W-2:0], (cnt_q == '0) ? lsb_q : 1'b0};

	assign s_est = sat_fx(SAT_W'(est_sel) + SAT_W'(sh16));
	assign s_err = sat_fx(SAT_W'(sh16));
	assign s_nv  = sat_fx(SAT_W'(vel_q) + SAT_W'(sh16));
	assign s_nve = sat_fx(SAT_W'(verr_q) + SAT_W'(sh16));
	assign s_np  = sat_fx(SAT_W'(pos_q) + SAT_W'(sh16));
	assign s_npe = sat_fx(SAT_W'(perr_q) + SAT_W'(sh16));
	assign s_rst = sat_fx(SAT_W'(prod_q));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_BMUL1: begin
				mul_a = MA_W'(meas_sel) - MA_W'(est_sel);
				mul_b = $signed({{(MB_W-GAIN_W){1'b0}}, g_q});
			end
			OP_BMUL2: begin
				mul_a = MA_W'(err_sel);
				mul_b = $signed({{(MB_W-GAIN_W-1){1'b0}}, one_minus_g});
			end
			OP_P1: begin
				mul_a = MA_W'(in_q.accel);
				mul_b = $signed({1'b0, in_q.time_step});
			end
			OP_P2: begin
				mul_a = $signed({{(MA_W-MERR_W){1'b0}}, in_q.accel_err});
				mul_b = $signed({1'b0, in_q.time_step});
			end
			OP_P3: begin
				mul_a = MA_W'(vel_q) + MA_W'(h_q);
				mul_b = $signed({1'b0, in_q.time_step});
			end
			OP_P4: begin
				mul_a = MA_W'(verr_q) + MA_W'(hv_q);
				mul_b = $signed({1'b0, in_q.time_step});
			end
			OP_R1: begin
				mul_a = MA_W'(perr_q);
				mul_b = RESET_SCALE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			vel_q <= '0;
			perr_q <= FX_UNSET;
			verr_q <= FX_UNSET;
			est_valid_q <= 1'b0;
		end else begin
			est_valid_q <= (cmd.op == OP_OUT) || (est_valid_q && est_stall);
			case (cmd.op)
				OP_LOAD: begin
					pos_q <= in_q.position;
					vel_q <= in_q.velocity;
					perr_q <= $signed({1'b0, in_q.pos_meas_err});
					verr_q <= $signed({1'b0, in_q.vel_meas_err});
				end
				OP_CLEAR: begin
					perr_q <= FX_UNSET;
					verr_q <= FX_UNSET;
				end
				OP_ADOPT: begin
					if (cmd.ch) begin
						vel_q <= meas_sel;
						verr_q <= $signed({1'b0, merr_sel});
					end else begin
						pos_q <= meas_sel;
						perr_q <= $signed({1'b0, merr_sel});
					end
				end
				OP_BMUL2: begin
					if (cmd.ch) vel_q <= s_est.val;
					else pos_q <= s_est.val;
				end
				OP_BWR: begin
					if (cmd.ch) verr_q <= s_err.val;
					else perr_q <= s_err.val;
				end
				OP_P5: begin
					pos_q <= np_q;
					vel_q <= nv_q;
					perr_q <= s_npe.val;
					verr_q <= nve_q;
				end
				OP_R2: begin
					vel_q <= '0;
					perr_q <= s_rst.val;
					verr_q <= FX_TEN;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				in_q <= meas;
				sat_q <= 1'b0;
			end
			OP_DIV_INIT: begin
				r_q <= DIVR_W'(err_sel[DATA_W-1:1]);
				lsb_q <= err_sel[0];
				sum_q <= DIVS_W'(err_sel) + DIVS_W'(merr_sel);
				cnt_q <= '0;
				g_q <= '0;
			end
			OP_DIV_STEP: begin
				if (rs >= DIVR_W'(sum_q)) begin
					r_q <= rs - DIVR_W'(sum_q);
					g_q <= {g_q[GAIN_W-2:0], 1'b1};
				end else begin
					r_q <= rs;
					g_q <= {g_q[GAIN_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			OP_BMUL2: sat_q <= sat_q | s_est.clip;
			OP_BWR: sat_q <= sat_q | s_err.clip;
			OP_P2: begin
				h_q <= sh17;
				nv_q <= s_nv.val;
				sat_q <= sat_q | s_nv.clip;
			end
			OP_P3: begin
				hv_q <= sh17;
				nve_q <= s_nve.val;
				sat_q <= sat_q | s_nve.clip;
			end
			OP_P4: begin
				np_q <= s_np.val;
				sat_q <= sat_q | s_np.clip;
			end
			OP_P5: sat_q <= sat_q | s_npe.clip;
			OP_R2: sat_q <= sat_q | s_rst.clip;
			OP_OUT: begin
				est_q.pos_estimate <= pos_q;
				est_q.vel_estimate <= vel_q;
				est_q.pos_error <= perr_q;
				est_q.vel_error <= verr_q;
				est_q.saturated <= sat_q;
			end
			default: ;
		endcase
	end

	assign stat.command = cmd_t'(in_q.command);
	assign stat.err_unset = (err_sel <= 0);
	assign stat.div_last = (cnt_q == DIV_LAST);
	assign stat.out_busy = est_valid_q && est_stall;
	assign est_valid = est_valid_q;
	assign est = est_q;
endmodule
`default_nettype wire

// ----- src/position_velocity_kalman_filter.sv -----
// Top level: position/velocity Kalman filter, controller plus datapath.
// Input channel meas/meas_valid/meas_stall carries one command item; output
// channel est/est_valid/est_stall returns one result item per command.
// An input item is taken only while the controller is idle; the block then
// works on that one item until its result sits in the output register.
// An update runs the 17-step restoring gain divider for each channel whose
// error is set; a channel whose error is unset adopts the measurement
// instead. All products come from the single shared 36x21 multiplier.
// The output register holds its item while est_stall is high; a new input
// item is still accepted and worked, and waits for the register to empty.
// Reset (arst_n low) clears position and velocity to zero, marks both errors
// unset (minus one), and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
module position_velocity_kalman_filter (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              meas_valid,
	output logic             meas_stall,
	input  pvkf_pkg::meas_t  meas,
	output logic             est_valid,
	input  wire              est_stall,
	output pvkf_pkg::est_t   est
);
	import pvkf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pvkf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.meas_valid (meas_valid),
		.meas_stall (meas_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	pvkf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.meas      (meas),
		.cmd       (cmd),
		.stat      (stat),
		.est_valid (est_valid),
		.est_stall (est_stall),
		.est       (est)
	);
endmodule
`default_nettype wire
